@@ rtl/core/fsn_pkg.sv @@
// ----------------------------------------------------------------------------
// fsn_pkg
// Shared types, constants and fixed-point helpers of the fractal simplex
// noise pipeline.
// ----------------------------------------------------------------------------
package fsn_pkg;

	localparam int MAX_OCTAVES = 8;
	localparam int OCT_STAGES  = 11;
	localparam int OCT_CNT_W   = 4;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_SEED  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OCT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PERS  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LAC   = 3'd4;

	localparam logic [31:0] FX_ONE      = 32'd4096;
	localparam logic [31:0] FX_HALF     = 32'd2048;
	localparam logic [31:0] SKEW_K      = 32'd1499;
	localparam logic [31:0] UNSKEW_K    = 32'd865;
	localparam logic [31:0] CORNER2_OFS = 32'hFFFF_F6C4;
	localparam logic [31:0] OUT_GAIN    = 32'd156809;
	localparam logic [31:0] PRIME_X     = 32'd501125321;
	localparam logic [31:0] PRIME_Y     = 32'd1136930381;
	localparam logic [31:0] HASH_MUL    = 32'h27d4_eb2d;
	localparam logic [31:0] CELL_MASK   = 32'hFFFF_F000;

	localparam logic [31:0] RST_SCALE = 32'd64;
	localparam logic [OCT_CNT_W-1:0] RST_OCT = 4'd1;
	localparam logic [31:0] RST_PERS  = 32'd2048;
	localparam logic [31:0] RST_LAC   = 32'd8192;

	localparam logic [31:0] GRAD_X [8] = '{32'd7094, 32'd7094, 32'd8192, 32'd8192,
		32'd4096, 32'hFFFF_F000, 32'd0, 32'd0};
	localparam logic [31:0] GRAD_Y [8] = '{32'd4096, 32'hFFFF_F000, 32'd0, 32'd0,
		32'd7094, 32'd7094, 32'd8192, 32'd8192};

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] weight;
		logic [31:0] sum;
	} oct_bus_t;

	function automatic logic [31:0] asr12(input logic [31:0] v);
		return {{12{v[31]}}, v[31:12]};
	endfunction

	function automatic logic [31:0] fxmul(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] p;
		p = a * b;
		return {{12{p[31]}}, p[31:12]};
	endfunction

endpackage

@@ rtl/core/fractal_simplex_noise_2d.sv @@
// ----------------------------------------------------------------------------
// fractal_simplex_noise_2d
// Fractal 2D simplex noise, one sample per clock, twelve fractional bits.
// ----------------------------------------------------------------------------
// Samples enter on in_valid/in_ready with sample_x and sample_y; each one
// produces exactly one noise_value transaction on out_valid/out_ready.
// Registers are written through cfg_valid/cfg_ready with cfg_index and
// cfg_data: 0 seed, 1 coordinate scale, 2 octave count, 3 persistence,
// 4 lacunarity; other indexes are ignored. Write them only while idle.
// Each sample is scaled by a registered multiply, then passes through all
// eight unrolled octave stages, whether or not an octave is enabled.
// Throughput is one sample per cycle unless the receiver stalls it.
// The whole pipeline advances together; when the receiver holds out_ready
// low with a result waiting, every stage holds and in_ready falls, so no
// transaction is lost or repeated. Reset clears all valid bits and loads
// the register defaults (seed 0, scale 64, one octave, persistence 0.5,
// lacunarity 2.0).
// ----------------------------------------------------------------------------
module fractal_simplex_noise_2d (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [31:0]                   sample_x,
	input  logic [31:0]                   sample_y,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [31:0]                   noise_value,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [fsn_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);

	logic [31:0] seed_q, scale_q, pers_q, lac_q;
	logic [fsn_pkg::OCT_CNT_W-1:0] oct_q, oct_sat;
	logic        en;
	logic        v_s0;
	fsn_pkg::oct_bus_t bus_s0;

	logic              oct_v [0:fsn_pkg::MAX_OCTAVES];
	fsn_pkg::oct_bus_t oct_b [0:fsn_pkg::MAX_OCTAVES];

	assign cfg_ready = 1'b1;
	assign en        = !out_valid || out_ready;
	assign in_ready  = en;
	assign oct_sat   = (oct_q > fsn_pkg::OCT_CNT_W'(fsn_pkg::MAX_OCTAVES))
		? fsn_pkg::OCT_CNT_W'(fsn_pkg::MAX_OCTAVES) : oct_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q  <= '0;
			scale_q <= fsn_pkg::RST_SCALE;
			oct_q   <= fsn_pkg::RST_OCT;
			pers_q  <= fsn_pkg::RST_PERS;
			lac_q   <= fsn_pkg::RST_LAC;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				fsn_pkg::CFG_SEED:  seed_q  <= cfg_data;
				fsn_pkg::CFG_SCALE: scale_q <= cfg_data;
				fsn_pkg::CFG_OCT:   oct_q   <= cfg_data[fsn_pkg::OCT_CNT_W-1:0];
				fsn_pkg::CFG_PERS:  pers_q  <= cfg_data;
				fsn_pkg::CFG_LAC:   lac_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else if (en) begin
			v_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bus_s0.x      <= sample_x * scale_q;
			bus_s0.y      <= sample_y * scale_q;
			bus_s0.weight <= fsn_pkg::FX_ONE;
			bus_s0.sum    <= '0;
		end
	end

	assign oct_v[0] = v_s0;
	assign oct_b[0] = bus_s0;

	for (genvar k = 0; k < fsn_pkg::MAX_OCTAVES; k++) begin : g_oct
		fsn_octave u_oct (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.active    (oct_sat > fsn_pkg::OCT_CNT_W'(k)),
			.seed      (seed_q),
			.pers      (pers_q),
			.lac       (lac_q),
			.in_valid  (oct_v[k]),
			.in_bus    (oct_b[k]),
			.out_valid (oct_v[k+1]),
			.out_bus   (oct_b[k+1])
		);
	end

	assign out_valid   = oct_v[fsn_pkg::MAX_OCTAVES];
	assign noise_value = oct_b[fsn_pkg::MAX_OCTAVES].sum;

	a_front_capture: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s0)
		else $error("accepted sample did not enter the front stage");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(noise_value))
		else $error("result changed while the receiver stalled");

	a_oct_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_index == fsn_pkg::CFG_OCT
		|=> oct_q == $past(cfg_data[fsn_pkg::OCT_CNT_W-1:0]))
		else $error("octave count write was lost");

endmodule

@@ rtl/core/fsn_octave.sv @@
// ----------------------------------------------------------------------------
// fsn_octave
// One octave of 2D simplex noise in an eleven-stage pipeline, with the next
// octave's coordinates and weight computed alongside.
// ----------------------------------------------------------------------------
module fsn_octave (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              active,
	input  logic [31:0]       seed,
	input  logic [31:0]       pers,
	input  logic [31:0]       lac,
	input  logic              in_valid,
	input  fsn_pkg::oct_bus_t in_bus,
	output logic              out_valid,
	output fsn_pkg::oct_bus_t out_bus
);

	logic              v_s [1:fsn_pkg::OCT_STAGES];
	fsn_pkg::oct_bus_t cary_s [1:fsn_pkg::OCT_STAGES-1];
	logic [31:0]       w_s [1:fsn_pkg::OCT_STAGES-1];

	logic [31:0] xo_s1, yo_s1, f_s1;
	logic [31:0] xo_s2, yo_s2, cx_s2, cy_s2;
	logic [31:0] xo_s3, yo_s3, cx_s3, cy_s3, hi_s3, hj_s3, g_s3;
	logic [31:0] dx_s4 [3], dy_s4 [3], a_s4 [3];
	logic [31:0] dx_s5 [3], dy_s5 [3], h_s5 [3], sx_s5 [3], sy_s5 [3];
	logic [31:0] gr_s6 [3], t_s6 [3];
	logic [31:0] gr_s7 [3], t2_s7 [3];
	logic [31:0] gr_s8 [3], t4_s8 [3];
	logic [31:0] n_s9 [3];
	logic [31:0] v_s10;

	logic [31:0] x0, y0, hi1, hj1, hi2, hj2;
	logic        lower;
	logic [31:0] tpre [3];

	always_comb begin
		x0    = xo_s3 - (cx_s3 - g_s3);
		y0    = yo_s3 - (cy_s3 - g_s3);
		lower = $signed(x0) > $signed(y0);
		hi2   = hi_s3 + fsn_pkg::PRIME_X;
		hj2   = hj_s3 + fsn_pkg::PRIME_Y;
		hi1   = lower ? hi2 : hi_s3;
		hj1   = lower ? hj_s3 : hj2;
	end

	always_comb begin
		for (int i = 0; i < 3; i++) tpre[i] = fsn_pkg::FX_HALF - sx_s5[i] - sy_s5[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= fsn_pkg::OCT_STAGES; i++) v_s[i] <= 1'b0;
		end else if (en) begin
			v_s[1] <= in_valid;
			for (int i = 2; i <= fsn_pkg::OCT_STAGES; i++) v_s[i] <= v_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cary_s[1].x      <= fsn_pkg::fxmul(in_bus.x, lac);
			cary_s[1].y      <= fsn_pkg::fxmul(in_bus.y, lac);
			cary_s[1].weight <= fsn_pkg::fxmul(pers, in_bus.weight);
			cary_s[1].sum    <= in_bus.sum;
			w_s[1]           <= in_bus.weight;
			for (int i = 2; i < fsn_pkg::OCT_STAGES; i++) begin
				cary_s[i] <= cary_s[i-1];
				w_s[i]    <= w_s[i-1];
			end

			xo_s1 <= in_bus.x;
			yo_s1 <= in_bus.y;
			f_s1  <= fsn_pkg::fxmul(fsn_pkg::SKEW_K, in_bus.x + in_bus.y);

			xo_s2 <= xo_s1;
			yo_s2 <= yo_s1;
			cx_s2 <= (xo_s1 + f_s1) & fsn_pkg::CELL_MASK;
			cy_s2 <= (yo_s1 + f_s1) & fsn_pkg::CELL_MASK;

			xo_s3 <= xo_s2;
			yo_s3 <= yo_s2;
			cx_s3 <= cx_s2;
			cy_s3 <= cy_s2;
			hi_s3 <= fsn_pkg::asr12(cx_s2) * fsn_pkg::PRIME_X;
			hj_s3 <= fsn_pkg::asr12(cy_s2) * fsn_pkg::PRIME_Y;
			g_s3  <= fsn_pkg::fxmul(fsn_pkg::UNSKEW_K, cx_s2 + cy_s2);

			dx_s4[0] <= x0;
			dy_s4[0] <= y0;
			dx_s4[1] <= (lower ? x0 - fsn_pkg::FX_ONE : x0) + fsn_pkg::UNSKEW_K;
			dy_s4[1] <= (lower ? y0 : y0 - fsn_pkg::FX_ONE) + fsn_pkg::UNSKEW_K;
			dx_s4[2] <= x0 + fsn_pkg::CORNER2_OFS;
			dy_s4[2] <= y0 + fsn_pkg::CORNER2_OFS;
			a_s4[0]  <= seed ^ hi_s3 ^ hj_s3;
			a_s4[1]  <= seed ^ hi1 ^ hj1;
			a_s4[2]  <= seed ^ hi2 ^ hj2;

			for (int i = 0; i < 3; i++) begin
				dx_s5[i] <= dx_s4[i];
				dy_s5[i] <= dy_s4[i];
				h_s5[i]  <= a_s4[i] * fsn_pkg::HASH_MUL;
				sx_s5[i] <= fsn_pkg::fxmul(dx_s4[i], dx_s4[i]);
				sy_s5[i] <= fsn_pkg::fxmul(dy_s4[i], dy_s4[i]);

				gr_s6[i] <= fsn_pkg::fxmul(fsn_pkg::GRAD_Y[h_s5[i][14:12]], dy_s5[i])
					+ fsn_pkg::fxmul(fsn_pkg::GRAD_X[h_s5[i][14:12]], dx_s5[i]);
				t_s6[i]  <= tpre[i][31] ? 32'd0 : tpre[i];

				gr_s7[i] <= gr_s6[i];
				t2_s7[i] <= fsn_pkg::fxmul(t_s6[i], t_s6[i]);

				gr_s8[i] <= gr_s7[i];
				t4_s8[i] <= fsn_pkg::fxmul(t2_s7[i], t2_s7[i]);

				n_s9[i]  <= fsn_pkg::fxmul(gr_s8[i], t4_s8[i]);
			end

			v_s10 <= fsn_pkg::fxmul(n_s9[0] + n_s9[1] + n_s9[2], fsn_pkg::OUT_GAIN);

			out_bus.x      <= cary_s[fsn_pkg::OCT_STAGES-1].x;
			out_bus.y      <= cary_s[fsn_pkg::OCT_STAGES-1].y;
			out_bus.weight <= cary_s[fsn_pkg::OCT_STAGES-1].weight;
			out_bus.sum    <= cary_s[fsn_pkg::OCT_STAGES-1].sum + (active ?
				fsn_pkg::fxmul(v_s10, w_s[fsn_pkg::OCT_STAGES-1]) : 32'd0);
		end
	end

	assign out_valid = v_s[fsn_pkg::OCT_STAGES];

endmodule
